@@ rtl/core/pth_sensor_compensation_top_defines.svh @@
// Assertion macros shared by the compensation core.
// No dependencies; included by files that carry assertions.
`ifndef PTH_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, off while in reset
`define PTHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pthc assertion failed");
// clocked check that also runs through reset
`define PTHC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pthc reset assertion failed");
`else
`define PTHC_ASSERT(lbl, prop)
`define PTHC_ASSERT_RST(lbl, prop)
`endif

`endif

@@ rtl/core/pthc_pkg.sv @@
// Shared constants for the pressure/temperature/humidity compensation core.
// No dependencies; imported by pthc_div and the top level.
package pthc_pkg;

  // divider datapath width
  localparam int DIV_W = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_B   = 3'd5;

  // compensation constants
  localparam logic signed [33:0] T_FINE_P_OFS = 34'sd128000;
  localparam logic [20:0]        P_RAW_FULL   = 21'd1048576;
  localparam logic signed [12:0] P_SCALE      = 13'sd3125;
  localparam logic signed [31:0] T_FINE_H_OFS = 32'sd76800;
  localparam logic signed [31:0] H_RND_A      = 32'sd16384;
  localparam logic signed [31:0] H_RND_B      = 32'sd32768;
  localparam logic signed [31:0] H_OFS_C      = 32'sd2097152;
  localparam logic signed [31:0] H_RND_D      = 32'sd8192;
  localparam logic signed [31:0] H_MAX        = 32'sd419430400;
  localparam logic signed [31:0] T_RND        = 32'sd128;
  localparam logic signed [63:0] P_BIAS_47    = 64'sh0000_8000_0000_0000;

  // items carried alongside the divider
  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] hx;
    logic               inval;
    logic               neg;
  } pthc_side_t;

endpackage

@@ rtl/core/pthc_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on pthc_pkg and the assertion macro header.
`include "pth_sensor_compensation_top_defines.svh"

module pthc_div
  import pthc_pkg::*;
#(
  parameter int W      = DIV_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [W-1:0]      in_dvd,
  input  logic [W-1:0]      in_dvs,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r    [1:W];
  logic [W-1:0]      rem_r    [1:W];
  logic [W-1:0]      dq_r     [1:W];
  logic [W-1:0]      dvs_r    [1:W];
  logic [SIDE_W-1:0] side_r   [1:W];
  logic              vld_nxt  [1:W];
  logic [W-1:0]      rem_nxt  [1:W];
  logic [W-1:0]      dq_nxt   [1:W];
  logic [W-1:0]      dvs_nxt  [1:W];
  logic [SIDE_W-1:0] side_nxt [1:W];

  // one shift/compare/subtract per stage; dq shifts dividend out, quotient in
  always_comb begin
    logic [W-1:0]      r;
    logic [W-1:0]      dq;
    logic [W-1:0]      dv;
    logic [SIDE_W-1:0] sd;
    logic              vv;
    logic [W:0]        sh;
    logic              qb;
    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        r  = '0;
        dq = in_dvd;
        dv = in_dvs;
        sd = in_side;
        vv = in_valid;
      end else begin
        r  = rem_r[i];
        dq = dq_r[i];
        dv = dvs_r[i];
        sd = side_r[i];
        vv = vld_r[i];
      end
      sh = {r, dq[W-1]};
      qb = (sh >= {1'b0, dv});
      rem_nxt[i+1]  = qb ? (sh[W-1:0] - dv) : sh[W-1:0];
      dq_nxt[i+1]   = {dq[W-2:0], qb};
      dvs_nxt[i+1]  = dv;
      side_nxt[i+1] = sd;
      vld_nxt[i+1]  = vv;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int i = 1; i <= W; i++) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_nxt[i];
      end
      rem_r[i]  <= rem_nxt[i];
      dq_r[i]   <= dq_nxt[i];
      dvs_r[i]  <= dvs_nxt[i];
      side_r[i] <= side_nxt[i];
    end
  end

  assign out_valid = vld_r[W];
  assign out_quo   = dq_r[W];
  assign out_side  = side_r[W];

  `PTHC_ASSERT(a_lat, out_valid |-> $past(in_valid, W))
  `PTHC_ASSERT(a_rem_lt_dvs, (vld_r[W] && (dvs_r[W] != '0)) |-> (rem_r[W] < dvs_r[W]))
  `PTHC_ASSERT(a_zero_dvs, (vld_r[W] && (dvs_r[W] == '0)) |-> (dq_r[W] == '1))
  `PTHC_ASSERT_RST(a_rst_clr, !rst_n |=> !vld_r[W])

endmodule

@@ rtl/core/pth_sensor_compensation_top.sv @@
// Top level of the pressure/temperature/humidity compensation core.
// Depends on pthc_pkg and pthc_div.

// A new reading set is taken every clock cycle (busy stays low). Each result
// is shown on the out_ ports for one cycle with out_valid; results come back
// in order and cannot be held off. The core is built around the 64-stage
// pipelined pressure divider, with nine stages of compensation ahead of it
// and five behind it.
// Calibration registers are written through cfg_we/cfg_idx/cfg_wdata; the user
// must write them only while no item is in flight, which the block does not enforce.
module pth_sensor_compensation_top
  import pthc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_raw_temp,
  input  logic [19:0]        in_raw_press,
  input  logic [15:0]        in_raw_hum,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [47:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_temp_centideg,
  output logic [31:0]        out_press_q24_8,
  output logic               out_press_invalid,
  output logic [16:0]        out_hum_q22_10
);

  // calibration registers
  logic [47:0] temp_calib_r, press_calib_a_r, press_calib_b_r, press_calib_c_r;
  logic [31:0] hum_calib_a_r;
  logic [39:0] hum_calib_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r    <= '0;
      press_calib_a_r <= '0;
      press_calib_b_r <= '0;
      press_calib_c_r <= '0;
      hum_calib_a_r   <= '0;
      hum_calib_b_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TEMP:    temp_calib_r    <= cfg_wdata;
        CFG_PRESS_A: press_calib_a_r <= cfg_wdata;
        CFG_PRESS_B: press_calib_b_r <= cfg_wdata;
        CFG_PRESS_C: press_calib_c_r <= cfg_wdata;
        CFG_HUM_A:   hum_calib_a_r   <= cfg_wdata[31:0];
        CFG_HUM_B:   hum_calib_b_r   <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]         h1, h3;
  logic signed [7:0]  h6;

  assign t1 = temp_calib_r[15:0];
  assign t2 = temp_calib_r[31:16];
  assign t3 = temp_calib_r[47:32];
  assign p1 = press_calib_a_r[15:0];
  assign p2 = press_calib_a_r[31:16];
  assign p3 = press_calib_a_r[47:32];
  assign p4 = press_calib_b_r[15:0];
  assign p5 = press_calib_b_r[31:16];
  assign p6 = press_calib_b_r[47:32];
  assign p7 = press_calib_c_r[15:0];
  assign p8 = press_calib_c_r[31:16];
  assign p9 = press_calib_c_r[47:32];
  assign h1 = hum_calib_a_r[7:0];
  assign h2 = hum_calib_a_r[23:8];
  assign h3 = hum_calib_a_r[31:24];
  assign h4 = hum_calib_b_r[15:0];
  assign h5 = hum_calib_b_r[31:16];
  assign h6 = hum_calib_b_r[39:32];

  // never stalls
  assign busy = 1'b0;

  // valid bits of the stages ahead of the divider
  logic [9:1] v_r;
  logic [9:1] v_nxt;
  assign v_nxt = {v_r[8:1], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: temperature products
  logic signed [31:0] tdiff, tdd;
  logic signed [31:0] s1_v1m_r, s1_dd_r, s1_v1m_nxt, s1_dd_nxt;
  logic [19:0]        s1_ap_r;
  logic [15:0]        s1_ah_r;

  assign tdiff      = $signed({15'd0, in_raw_temp[19:3]}) - $signed({15'd0, t1, 1'b0});
  assign tdd        = $signed({16'd0, in_raw_temp[19:4]}) - $signed({16'd0, t1});
  assign s1_v1m_nxt = tdiff * 32'(t2);
  assign s1_dd_nxt  = tdd * tdd;

  always_ff @(posedge clk) begin
    s1_v1m_r <= s1_v1m_nxt;
    s1_dd_r  <= s1_dd_nxt;
    s1_ap_r  <= in_raw_press;
    s1_ah_r  <= in_raw_hum;
  end

  // stage 2: second temperature term
  logic signed [31:0] s2_v1_r, s2_m_r, s2_v1_nxt, s2_m_nxt;
  logic [19:0]        s2_ap_r;
  logic [15:0]        s2_ah_r;

  assign s2_v1_nxt = s1_v1m_r >>> 11;
  assign s2_m_nxt  = (s1_dd_r >>> 12) * 32'(t3);

  always_ff @(posedge clk) begin
    s2_v1_r <= s2_v1_nxt;
    s2_m_r  <= s2_m_nxt;
    s2_ap_r <= s1_ap_r;
    s2_ah_r <= s1_ah_r;
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tf_r, s3_tf_nxt;
  logic [19:0]        s3_ap_r;
  logic [15:0]        s3_ah_r;

  assign s3_tf_nxt = s2_v1_r + (s2_m_r >>> 14);

  always_ff @(posedge clk) begin
    s3_tf_r <= s3_tf_nxt;
    s3_ap_r <= s2_ap_r;
    s3_ah_r <= s2_ah_r;
  end

  // stage 4: centidegrees, first pressure and humidity products
  logic signed [33:0] pa;
  logic signed [67:0] aa_full;
  logic signed [49:0] ap5_full, ap2_full;
  logic signed [31:0] hxo;
  logic signed [31:0] s4_tc_r, s4_tc_nxt;
  logic signed [63:0] s4_aa_r;
  logic signed [49:0] s4_ap5_r, s4_ap2_r;
  logic signed [31:0] s4_h5x_r, s4_xh6_r, s4_xh3_r, s4_h5x_nxt, s4_xh6_nxt, s4_xh3_nxt;
  logic [19:0]        s4_ap_r;
  logic [15:0]        s4_ah_r;

  assign s4_tc_nxt  = (s3_tf_r * 32'sd5 + T_RND) >>> 8;
  assign pa         = 34'(s3_tf_r) - T_FINE_P_OFS;
  assign aa_full    = pa * pa;
  assign ap5_full   = pa * p5;
  assign ap2_full   = pa * p2;
  assign hxo        = s3_tf_r - T_FINE_H_OFS;
  assign s4_h5x_nxt = 32'(h5) * hxo;
  assign s4_xh6_nxt = hxo * 32'(h6);
  assign s4_xh3_nxt = hxo * $signed({24'd0, h3});

  always_ff @(posedge clk) begin
    s4_tc_r  <= s4_tc_nxt;
    s4_aa_r  <= aa_full[63:0];
    s4_ap5_r <= ap5_full;
    s4_ap2_r <= ap2_full;
    s4_h5x_r <= s4_h5x_nxt;
    s4_xh6_r <= s4_xh6_nxt;
    s4_xh3_r <= s4_xh3_nxt;
    s4_ap_r  <= s3_ap_r;
    s4_ah_r  <= s3_ah_r;
  end

  // stage 5: square terms scaled, humidity f1 and g factors
  logic signed [79:0] aap6_full, aap3_full;
  logic signed [63:0] s5_aap6_r, s5_aap3_r;
  logic signed [49:0] s5_ap5_r, s5_ap2_r;
  logic signed [31:0] s5_f1_r, s5_g1_r, s5_g2_r, s5_f1_nxt, s5_g1_nxt, s5_g2_nxt;
  logic signed [31:0] s5_tc_r;
  logic [19:0]        s5_ap_r;

  assign aap6_full = s4_aa_r * p6;
  assign aap3_full = s4_aa_r * p3;
  assign s5_f1_nxt = ($signed({2'd0, s4_ah_r, 14'd0}) - (32'(h4) <<< 20) - s4_h5x_r
                      + H_RND_A) >>> 15;
  assign s5_g1_nxt = s4_xh6_r >>> 10;
  assign s5_g2_nxt = (s4_xh3_r >>> 11) + H_RND_B;

  always_ff @(posedge clk) begin
    s5_aap6_r <= aap6_full[63:0];
    s5_aap3_r <= aap3_full[63:0];
    s5_ap5_r  <= s4_ap5_r;
    s5_ap2_r  <= s4_ap2_r;
    s5_f1_r   <= s5_f1_nxt;
    s5_g1_r   <= s5_g1_nxt;
    s5_g2_r   <= s5_g2_nxt;
    s5_tc_r   <= s4_tc_r;
    s5_ap_r   <= s4_ap_r;
  end

  // stage 6: pressure offset b and sensitivity sums
  logic signed [63:0] s6_b_r, s6_a2_r, s6_b_nxt, s6_a2_nxt;
  logic signed [31:0] s6_gm_r, s6_gm_nxt, s6_f1_r, s6_tc_r;
  logic [19:0]        s6_ap_r;

  assign s6_b_nxt  = s5_aap6_r + (64'(s5_ap5_r) <<< 17) + (64'(p4) <<< 35);
  assign s6_a2_nxt = (s5_aap3_r >>> 8) + (64'(s5_ap2_r) <<< 12);
  assign s6_gm_nxt = s5_g1_r * s5_g2_r;

  always_ff @(posedge clk) begin
    s6_b_r  <= s6_b_nxt;
    s6_a2_r <= s6_a2_nxt;
    s6_gm_r <= s6_gm_nxt;
    s6_f1_r <= s5_f1_r;
    s6_tc_r <= s5_tc_r;
    s6_ap_r <= s5_ap_r;
  end

  // stage 7: divisor product, dividend before scale, humidity g*H2
  logic signed [80:0] m_full;
  logic [20:0]        pdiff;
  logic signed [31:0] hg;
  logic signed [63:0] s7_m_r, s7_pnum_r, s7_pnum_nxt;
  logic signed [31:0] s7_gh_r, s7_gh_nxt, s7_f1_r, s7_tc_r;

  assign m_full      = (s6_a2_r + P_BIAS_47) * $signed({1'b0, p1});
  assign pdiff       = P_RAW_FULL - {1'b0, s6_ap_r};
  assign s7_pnum_nxt = $signed({12'd0, pdiff, 31'd0}) - s6_b_r;
  assign hg          = (s6_gm_r >>> 10) + H_OFS_C;
  assign s7_gh_nxt   = hg * 32'(h2);

  always_ff @(posedge clk) begin
    s7_m_r    <= m_full[63:0];
    s7_pnum_r <= s7_pnum_nxt;
    s7_gh_r   <= s7_gh_nxt;
    s7_f1_r   <= s6_f1_r;
    s7_tc_r   <= s6_tc_r;
  end

  // stage 8: divisor, scaled dividend, humidity f2
  logic signed [76:0] num_full;
  logic signed [63:0] s8_dvs_r, s8_num_r, s8_dvs_nxt;
  logic signed [31:0] s8_f2_r, s8_f2_nxt, s8_f1_r, s8_tc_r;

  assign s8_dvs_nxt = s7_m_r >>> 33;
  assign num_full   = s7_pnum_r * P_SCALE;
  assign s8_f2_nxt  = (s7_gh_r + H_RND_D) >>> 14;

  always_ff @(posedge clk) begin
    s8_dvs_r <= s8_dvs_nxt;
    s8_num_r <= num_full[63:0];
    s8_f2_r  <= s8_f2_nxt;
    s8_f1_r  <= s7_f1_r;
    s8_tc_r  <= s7_tc_r;
  end

  // stage 9: magnitudes and signs for the divider, humidity f1*f2
  logic [DIV_W-1:0] s9_ua_r, s9_ub_r, s9_ua_nxt, s9_ub_nxt;
  pthc_side_t       s9_side_r, s9_side_nxt;

  assign s9_ua_nxt = s8_num_r[63] ? (64'd0 - s8_num_r) : s8_num_r;
  assign s9_ub_nxt = s8_dvs_r[63] ? (64'd0 - s8_dvs_r) : s8_dvs_r;
  always_comb begin
    s9_side_nxt.tc    = s8_tc_r;
    s9_side_nxt.hx    = s8_f1_r * s8_f2_r;
    s9_side_nxt.inval = (s8_dvs_r == 64'sd0);
    s9_side_nxt.neg   = s8_num_r[63] ^ s8_dvs_r[63];
  end

  always_ff @(posedge clk) begin
    s9_ua_r   <= s9_ua_nxt;
    s9_ub_r   <= s9_ub_nxt;
    s9_side_r <= s9_side_nxt;
  end

  // pressure divide
  logic             dv_valid;
  logic [DIV_W-1:0] dv_quo;
  pthc_side_t       dv_side;

  pthc_div #(
    .W      (DIV_W),
    .SIDE_W ($bits(pthc_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[9]),
    .in_dvd    (s9_ua_r),
    .in_dvs    (s9_ub_r),
    .in_side   (s9_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // post-divide valid bits
  logic [4:0] q_v_r, q_v_nxt;
  assign q_v_nxt = {q_v_r[3:0], dv_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= '0;
    end else begin
      q_v_r <= q_v_nxt;
    end
  end

  // post 0: signed quotient, humidity s*s
  logic signed [31:0] hs;
  logic signed [63:0] q0_p_r, q0_p_nxt;
  logic signed [31:0] q0_ss_r, q0_ss_nxt, q0_hx_r, q0_tc_r;
  logic               q0_inval_r;

  assign q0_p_nxt  = dv_side.neg ? (64'sd0 - $signed(dv_quo)) : $signed(dv_quo);
  assign hs        = dv_side.hx >>> 15;
  assign q0_ss_nxt = hs * hs;

  always_ff @(posedge clk) begin
    q0_p_r     <= q0_p_nxt;
    q0_ss_r    <= q0_ss_nxt;
    q0_hx_r    <= dv_side.hx;
    q0_tc_r    <= dv_side.tc;
    q0_inval_r <= dv_side.inval;
  end

  // post 1: partial products of ps*ps, P8 term, humidity H1 term
  logic signed [63:0] ps;
  logic signed [79:0] e2m_full;
  logic [63:0]        q1_ll_r, q1_ll_nxt;
  logic [31:0]        q1_lh_r, q1_lh_nxt;
  logic signed [63:0] q1_e2m_r, q1_p_r;
  logic signed [31:0] q1_t_r, q1_t_nxt, q1_hx_r, q1_tc_r;
  logic               q1_inval_r;

  assign ps        = q0_p_r >>> 13;
  assign q1_ll_nxt = ps[31:0] * ps[31:0];
  assign q1_lh_nxt = ps[31:0] * ps[63:32];
  assign e2m_full  = q0_p_r * p8;
  assign q1_t_nxt  = (q0_ss_r >>> 7) * $signed({24'd0, h1});

  always_ff @(posedge clk) begin
    q1_ll_r    <= q1_ll_nxt;
    q1_lh_r    <= q1_lh_nxt;
    q1_e2m_r   <= e2m_full[63:0];
    q1_p_r     <= q0_p_r;
    q1_t_r     <= q1_t_nxt;
    q1_hx_r    <= q0_hx_r;
    q1_tc_r    <= q0_tc_r;
    q1_inval_r <= q0_inval_r;
  end

  // post 2: ps squared, P8 term shifted, humidity clamp
  logic signed [31:0] hx2, hcl;
  logic signed [63:0] q2_sq_r, q2_sq_nxt, q2_e2_r, q2_p_r;
  logic [16:0]        q2_hum_r;
  logic signed [31:0] q2_tc_r;
  logic               q2_inval_r;

  assign q2_sq_nxt = $signed(q1_ll_r + {q1_lh_r[30:0], 33'd0});
  assign hx2       = q1_hx_r - (q1_t_r >>> 4);
  always_comb begin
    if (hx2 < 32'sd0) begin
      hcl = 32'sd0;
    end else if (hx2 > H_MAX) begin
      hcl = H_MAX;
    end else begin
      hcl = hx2;
    end
  end

  always_ff @(posedge clk) begin
    q2_sq_r    <= q2_sq_nxt;
    q2_e2_r    <= q1_e2m_r >>> 19;
    q2_p_r     <= q1_p_r;
    q2_hum_r   <= hcl[28:12];
    q2_tc_r    <= q1_tc_r;
    q2_inval_r <= q1_inval_r;
  end

  // post 3: P9 term
  logic signed [79:0] e1m_full;
  logic signed [63:0] q3_e1m_r, q3_e2_r, q3_p_r;
  logic [16:0]        q3_hum_r;
  logic signed [31:0] q3_tc_r;
  logic               q3_inval_r;

  assign e1m_full = q2_sq_r * p9;

  always_ff @(posedge clk) begin
    q3_e1m_r   <= e1m_full[63:0];
    q3_e2_r    <= q2_e2_r;
    q3_p_r     <= q2_p_r;
    q3_hum_r   <= q2_hum_r;
    q3_tc_r    <= q2_tc_r;
    q3_inval_r <= q2_inval_r;
  end

  // post 4: final pressure and output registers
  logic signed [63:0] psum;
  logic [31:0]        q4_press_r, q4_press_nxt;
  logic [16:0]        q4_hum_r;
  logic signed [31:0] q4_tc_r;
  logic               q4_inval_r;

  assign psum         = ((q3_p_r + (q3_e1m_r >>> 25) + q3_e2_r) >>> 8) + (64'(p7) <<< 4);
  assign q4_press_nxt = q3_inval_r ? 32'd0 : psum[31:0];

  always_ff @(posedge clk) begin
    q4_press_r <= q4_press_nxt;
    q4_hum_r   <= q3_hum_r;
    q4_tc_r    <= q3_tc_r;
    q4_inval_r <= q3_inval_r;
  end

  assign out_valid         = q_v_r[4];
  assign out_temp_centideg = q4_tc_r;
  assign out_press_q24_8   = q4_press_r;
  assign out_press_invalid = q4_inval_r;
  assign out_hum_q22_10    = q4_hum_r;

endmodule
